>>> rtl/pdhb_pkg.sv
// ----------------------------------------------------------------------------
// pdhb_pkg: shared types and constants for the periodic 2-D histogram binner
// Payload structs, configuration view, register codes, fixed-point constants.
// ----------------------------------------------------------------------------
package pdhb_pkg;

	localparam int MAX_BINS_H = 64;
	localparam int MAX_BINS_V = 64;
	localparam int COUNT_BITS = 24;

	localparam int DEPTH  = MAX_BINS_H * MAX_BINS_V;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam int Q_W       = 24;  // Q8.16 positions, distances, inverse widths
	localparam int BINS_W    = 7;
	localparam int REP_W     = 5;
	localparam int OUT_W     = 24;
	localparam int ADDED_W   = 10;
	localparam int COL_W     = 6;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 24;

	localparam logic [REP_W-1:0]   MAX_REPEATS = 5'd16;
	localparam logic [ADDED_W-1:0] MAX_ADDED   = 10'd512;
	localparam logic [OUT_W-1:0]   OUT_MAX     = 24'hFFFFFF;

	// shift multipliers, Q.16
	localparam int                MULT_W      = 21;
	localparam logic [MULT_W-1:0] HALF_Q16    = 21'd32768;
	localparam logic [MULT_W-1:0] SHIFT_V_Q16 = 21'd158218;  // 1 + sqrt(2)

	// bin index reduction, one digit per cycle
	localparam int QUO_W     = 24;
	localparam int DIGIT_W   = 4;
	localparam int MOD_STEPS = QUO_W / DIGIT_W;
	localparam int STEP_W    = $clog2(MOD_STEPS);

	localparam logic CMD_BIN  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BINS_H    = 4'd0,
		REG_BINS_V    = 4'd1,
		REG_INV_H     = 4'd2,
		REG_INV_V     = 4'd3,
		REG_WRAP_H    = 4'd4,
		REG_WRAP_V    = 4'd5,
		REG_REPEATS_H = 4'd6,
		REG_REPEATS_V = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic             command;
		logic [Q_W-1:0]   coord_h;
		logic [Q_W-1:0]   coord_v;
		logic [COL_W-1:0] read_col;
		logic [COL_W-1:0] read_row;
	} cmd_t;

	typedef struct packed {
		logic [OUT_W-1:0]   bin_count;
		logic [ADDED_W-1:0] added;
		logic               saturated;
	} res_t;

	// effective (clamped) configuration
	typedef struct packed {
		logic [BINS_W-1:0] nh;
		logic [BINS_W-1:0] nv;
		logic [Q_W-1:0]    inv_h;
		logic [Q_W-1:0]    inv_v;
		logic [Q_W-1:0]    dist_h;
		logic [Q_W-1:0]    dist_v;
		logic [REP_W-1:0]  rh;
		logic [REP_W-1:0]  rv;
	} cfg_t;

	function automatic logic [OUT_W-1:0] count_to_out(input count_t c);
		logic [31:0] c32;
		c32 = 32'(c);
		if (c32 > 32'(OUT_MAX))
			return OUT_MAX;
		return OUT_W'(c32);
	endfunction

endpackage

>>> rtl/periodic_2d_histogram_binner.sv
// ----------------------------------------------------------------------------
// periodic_2d_histogram_binner: 2-D histogram of periodic image positions
// Bins shifted Q8.16 positions into a saturating count memory; reads counts.
// ----------------------------------------------------------------------------
// Usage
//   cmd channel (cmd_valid/cmd_stall/cmd) takes one command per transaction:
//   a bin command with coord_h/coord_v, or a read command with read_col/
//   read_row. Each command gives exactly one transaction on the res channel
//   (res_valid/res_stall/res). cfg_valid/cfg_ready/cfg_index/cfg_data write
//   the setup registers; cfg_ready is always high.
//   One command at a time. A read command reads the count memory when it
//   is accepted; the count is registered, then loaded into the result. A bin
//   command performs 2 x repeats_h x repeats_v increments, each one set by the
//   index units (two multiplies, rounding, modulo reduction) plus one
//   read-modify-write of the count memory, and then loads its result.
//   Reset: state and control registers take their reset values, then a
//   clearing pass writes zero to all 4096 bins with cmd_stall held high.
//   A result waits in the output register while res_stall is high; the next
//   command is accepted meanwhile and only its completion waits.
// ----------------------------------------------------------------------------
module periodic_2d_histogram_binner import pdhb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_START = 7'b0000100,
		ST_WAIT  = 7'b0001000,
		ST_WRITE = 7'b0010000,
		ST_READ  = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   clr_q;
	cmd_t                cmd_q;
	logic                inrange_q;
	logic [3:0]          xx_q, yy_q;
	logic                pass_q;
	logic [ADDED_W-1:0]  added_q;
	logic                sat_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [OUT_W-1:0]    cnt_q;
	logic                res_valid_q;
	res_t                res_q;

	cfg_t                cfg;
	logic [MULT_W-1:0]   mult_h, mult_v;
	logic                done_h, done_v;
	logic [BINS_W-1:0]   rem_h, rem_v;
	logic [ADDR_W-1:0]   bin_addr, rd_addr;
	logic                rd_inrange;
	logic                mem_we, mem_re;
	logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
	count_t              mem_wdata, mem_rdata;
	logic                accept, last_x, last_y, at_ceil, res_load;

	assign cfg_ready = 1'b1;

	pdhb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_valid),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	assign mult_h = MULT_W'({xx_q, 16'h0000}) + (pass_q ? HALF_Q16 : '0);
	assign mult_v = MULT_W'({yy_q, 16'h0000}) + (pass_q ? SHIFT_V_Q16 : '0);

	pdhb_idx u_idx_h (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == ST_START),
		.coord     (cmd_q.coord_h),
		.wrap_dist (cfg.dist_h),
		.mult      (mult_h),
		.inv       (cfg.inv_h),
		.nb        (cfg.nh),
		.done      (done_h),
		.rem       (rem_h)
	);

	pdhb_idx u_idx_v (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == ST_START),
		.coord     (cmd_q.coord_v),
		.wrap_dist (cfg.dist_v),
		.mult      (mult_v),
		.inv       (cfg.inv_v),
		.nb        (cfg.nv),
		.done      (done_v),
		.rem       (rem_v)
	);

	// row-major: row * MAX_BINS_H + col
	assign bin_addr = ADDR_W'(32'(rem_v) * 32'(MAX_BINS_H) + 32'(rem_h));
	assign rd_addr  = ADDR_W'(32'(cmd.read_row) * 32'(MAX_BINS_H) + 32'(cmd.read_col));
	assign rd_inrange = (32'(cmd.read_col) < 32'(MAX_BINS_H)) &&
		(32'(cmd.read_row) < 32'(MAX_BINS_V));

	assign accept  = cmd_valid && (state_q == ST_IDLE);
	assign last_x  = ({1'b0, xx_q} == cfg.rh - 5'd1);
	assign last_y  = ({1'b0, yy_q} == cfg.rv - 5'd1);
	assign at_ceil = &mem_rdata;
	assign res_load = (state_q == ST_FIN) && (!res_valid_q || !res_stall);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = mem_rdata + 1'b1;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == ST_WRITE) begin
			mem_we = !at_ceil;
		end
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = bin_addr;
		if (accept && cmd.command == CMD_READ) begin
			mem_re    = 1'b1;
			mem_raddr = rd_addr;
		end else if (state_q == ST_WAIT && done_h && done_v) begin
			mem_re = 1'b1;
		end
	end

	pdhb_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			xx_q        <= '0;
			yy_q        <= '0;
			pass_q      <= 1'b0;
			added_q     <= '0;
			sat_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= res_load || (res_valid_q && res_stall);

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						xx_q    <= '0;
						yy_q    <= '0;
						pass_q  <= 1'b0;
						added_q <= '0;
						sat_q   <= 1'b0;
						if (cmd.command == CMD_READ)
							state_q <= ST_READ;
						else if (cfg.rh == '0 || cfg.rv == '0)
							state_q <= ST_FIN;
						else
							state_q <= ST_START;
					end
				end
				ST_START: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (done_h && done_v)
						state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (at_ceil)
						sat_q <= 1'b1;
					else
						added_q <= added_q + 1'b1;
					pass_q <= !pass_q;
					if (pass_q && last_y && last_x)
						state_q <= ST_FIN;
					else
						state_q <= ST_START;
					if (pass_q) begin
						if (last_y) begin
							yy_q <= '0;
							if (!last_x)
								xx_q <= xx_q + 1'b1;
						end else begin
							yy_q <= yy_q + 1'b1;
						end
					end
				end
				ST_READ: state_q <= ST_FIN;
				ST_FIN: begin
					if (res_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			inrange_q <= rd_inrange;
		end
		if (state_q == ST_WAIT && done_h && done_v)
			addr_q <= bin_addr;
		if (state_q == ST_READ)
			cnt_q <= inrange_q ? count_to_out(mem_rdata) : '0;
		if (res_load) begin
			if (cmd_q.command == CMD_READ) begin
				res_q.bin_count <= cnt_q;
				res_q.added     <= '0;
				res_q.saturated <= 1'b0;
			end else begin
				res_q.bin_count <= '0;
				res_q.added     <= added_q;
				res_q.saturated <= sat_q;
			end
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> rtl/pdhb_ram.sv
// ----------------------------------------------------------------------------
// pdhb_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module pdhb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

>>> rtl/pdhb_cfg.sv
// ----------------------------------------------------------------------------
// pdhb_cfg: configuration register file
// Holds the eight setup registers and presents them, bin counts and repeats clamped.
// ----------------------------------------------------------------------------
module pdhb_cfg import pdhb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [CFG_IDX_W-1:0] index,
	input  logic [CFG_DAT_W-1:0] data,
	output cfg_t                 cfg
);

	logic [BINS_W-1:0] bins_h_q, bins_v_q;
	logic [Q_W-1:0]    inv_h_q, inv_v_q, wrap_h_q, wrap_v_q;
	logic [REP_W-1:0]  rep_h_q, rep_v_q;

	function automatic logic [BINS_W-1:0] clamp_bins(input logic [BINS_W-1:0] n,
			input int maxn);
		if (n == '0)
			return BINS_W'(1);
		if (32'(n) > 32'(maxn))
			return BINS_W'(maxn);
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_h_q <= 7'd64;
			bins_v_q <= 7'd64;
			inv_h_q  <= 24'd65536;
			inv_v_q  <= 24'd65536;
			wrap_h_q <= '0;
			wrap_v_q <= '0;
			rep_h_q  <= 5'd1;
			rep_v_q  <= 5'd1;
		end else if (we) begin
			unique case (index)
				REG_BINS_H:    bins_h_q <= data[BINS_W-1:0];
				REG_BINS_V:    bins_v_q <= data[BINS_W-1:0];
				REG_INV_H:     inv_h_q  <= data[Q_W-1:0];
				REG_INV_V:     inv_v_q  <= data[Q_W-1:0];
				REG_WRAP_H:    wrap_h_q <= data[Q_W-1:0];
				REG_WRAP_V:    wrap_v_q <= data[Q_W-1:0];
				REG_REPEATS_H: rep_h_q  <= data[REP_W-1:0];
				REG_REPEATS_V: rep_v_q  <= data[REP_W-1:0];
				default: ;  // unknown index: ignored
			endcase
		end
	end

	always_comb begin
		cfg.nh     = clamp_bins(bins_h_q, MAX_BINS_H);
		cfg.nv     = clamp_bins(bins_v_q, MAX_BINS_V);
		cfg.inv_h  = inv_h_q;
		cfg.inv_v  = inv_v_q;
		cfg.dist_h = wrap_h_q;
		cfg.dist_v = wrap_v_q;
		cfg.rh     = (rep_h_q > MAX_REPEATS) ? MAX_REPEATS : rep_h_q;
		cfg.rv     = (rep_v_q > MAX_REPEATS) ? MAX_REPEATS : rep_v_q;
	end

endmodule

>>> rtl/pdhb_idx.sv
// ----------------------------------------------------------------------------
// pdhb_idx: bin index unit for one axis
// Shifts a position, scales by the inverse bin width with round-half-up,
// then reduces modulo the bin count four quotient bits per cycle.
// ----------------------------------------------------------------------------
module pdhb_idx import pdhb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [Q_W-1:0]    coord,
	input  logic [Q_W-1:0]    wrap_dist,
	input  logic [MULT_W-1:0] mult,
	input  logic [Q_W-1:0]    inv,
	input  logic [BINS_W-1:0] nb,
	output logic              done,
	output logic [BINS_W-1:0] rem
);

	typedef enum logic [5:0] {
		P_IDLE = 6'b000001,
		P_ADD  = 6'b000010,
		P_MUL2 = 6'b000100,
		P_RND  = 6'b001000,
		P_MOD  = 6'b010000,
		P_DONE = 6'b100000
	} phase_t;

	localparam int PROD1_W = MULT_W + Q_W;         // shift product, Q.32
	localparam int SUM1_W  = PROD1_W + 1;
	localparam int P16_W   = SUM1_W - 16;
	localparam int PROD2_W = P16_W + Q_W;          // scaled position, Q.32
	localparam int SUM2_W  = PROD2_W + 1;
	localparam logic [SUM1_W-1:0] RND_Q16 = SUM1_W'(32768);
	localparam logic [SUM2_W-1:0] RND_Q32 = SUM2_W'(64'h8000_0000);

	phase_t               phase_q;
	logic [PROD1_W-1:0]   prod1_q;
	logic [P16_W-1:0]     p16_q;
	logic [PROD2_W-1:0]   prod2_q;
	logic [QUO_W-1:0]     quo_q;
	logic [BINS_W-1:0]    rem_q;
	logic [STEP_W-1:0]    step_q;
	logic [SUM1_W-1:0]    sum1;
	logic [SUM2_W-1:0]    sum2;
	logic [BINS_W-1:0]    rem_nxt;

	function automatic logic [BINS_W-1:0] mod_bit(input logic [BINS_W-1:0] r,
			input logic b, input logic [BINS_W-1:0] n);
		logic [BINS_W:0] t;
		t = {r, b};
		if (t >= {1'b0, n})
			t = t - {1'b0, n};
		return t[BINS_W-1:0];
	endfunction

	assign sum1 = SUM1_W'({coord, 16'h0000}) + SUM1_W'(prod1_q) + RND_Q16;
	assign sum2 = SUM2_W'(prod2_q) + RND_Q32;

	always_comb begin
		rem_nxt = rem_q;
		for (int i = 0; i < DIGIT_W; i++)
			rem_nxt = mod_bit(rem_nxt, quo_q[QUO_W-1-i], nb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			step_q  <= '0;
		end else begin
			unique case (phase_q) inside
				P_IDLE, P_DONE: begin
					if (start)
						phase_q <= P_ADD;
				end
				P_ADD:  phase_q <= P_MUL2;
				P_MUL2: phase_q <= P_RND;
				P_RND: begin
					phase_q <= P_MOD;
					step_q  <= '0;
				end
				P_MOD: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(MOD_STEPS - 1))
						phase_q <= P_DONE;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			prod1_q <= PROD1_W'(mult) * PROD1_W'(wrap_dist);
		if (phase_q == P_ADD)
			p16_q <= sum1[SUM1_W-1:16];
		if (phase_q == P_MUL2)
			prod2_q <= PROD2_W'(p16_q) * PROD2_W'(inv);
		if (phase_q == P_RND) begin
			quo_q <= QUO_W'(sum2[SUM2_W-1:32]);
			rem_q <= '0;
		end
		if (phase_q == P_MOD) begin
			rem_q <= rem_nxt;
			quo_q <= quo_q << DIGIT_W;
		end
	end

	assign done = (phase_q == P_DONE);
	assign rem  = rem_q;

endmodule

>>> rtl/pdhb_chk.sv
// ----------------------------------------------------------------------------
// pdhb_chk: port-level checker for the histogram binner
// Watches the command, result and setup channels over time.
// ----------------------------------------------------------------------------
module pdhb_chk import pdhb_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cmd_valid,
	input logic                 cmd_stall,
	input logic                 res_valid,
	input logic                 res_stall,
	input res_t                 res,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	// a stalled result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// one command in flight: the cycle after a transaction is always stalled
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command accepted back to back");

	// read results carry no increment info, bin results carry no count
	a_res_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.bin_count != '0 |-> res.added == '0 && !res.saturated)
		else $error("mixed read and bin result fields");

	// increments bounded; a dropped increment means fewer than the maximum
	a_added: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.added <= MAX_ADDED &&
			!(res.saturated && res.added == MAX_ADDED))
		else $error("increment count out of range");

	// setup writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("setup write refused");

endmodule

bind periodic_2d_histogram_binner pdhb_chk u_pdhb_chk (.*);
